### rtl/rpa_pkg.sv
// package for the rotate-about-axis unit: sizes, latencies, cordic table and
// the record types that travel down the cell chains
// no dependencies
package rpa_pkg;

  localparam int TRIG_ITERATIONS = 24;
  localparam int TRIG_CELLS = (TRIG_ITERATIONS > 32) ? 32 : TRIG_ITERATIONS;
  localparam int SQRT_CELLS = 32;
  localparam int DIV_CELLS = 31;
  localparam int NORM_REGS = 4;
  localparam int FRONT_REGS = NORM_REGS + SQRT_CELLS + DIV_CELLS;
  localparam int TRIG_DELAY = FRONT_REGS - TRIG_CELLS;
  localparam int BACK_REGS = 8;
  localparam int LATENCY = 1 + FRONT_REGS + BACK_REGS;

  localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;
  localparam logic signed [32:0] ONE_Q30 = 33'sd1073741824;
  localparam logic signed [39:0] COORD_MAX = 40'sd2147483647;
  localparam logic signed [39:0] COORD_MIN = -40'sd2147483648;

  localparam logic [31:0] ATAN_TURNS [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
    32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001,
    32'h00000000, 32'h00000000
  };

  typedef enum logic [1:0] {
    QUAD_0,
    QUAD_90,
    QUAD_180,
    QUAD_270
  } quad_e;

  typedef struct packed {
    logic [2:0][31:0] p;
    logic [2:0][31:0] piv;
    logic [2:0]       neg;
    logic             zero;
  } side_t;

  typedef struct packed {
    side_t            side;
    logic [2:0][31:0] mag;
    logic [63:0]      n;
    logic [33:0]      rem;
    logic [31:0]      root;
  } sqrt_t;

  typedef struct packed {
    side_t            side;
    logic [31:0]      r;
    logic [2:0][31:0] rem;
    logic [2:0][30:0] dbits;
    logic [2:0][30:0] quo;
  } divs_t;

  typedef struct packed {
    logic signed [32:0] x;
    logic signed [32:0] y;
    logic signed [32:0] z;
    quad_e              quad;
  } cordic_t;

  typedef struct packed {
    logic signed [31:0] cosv;
    logic signed [31:0] sinv;
  } trig_t;

endpackage

### rtl/rpa_sqrt_cell.sv
// one digit of the integer square root: two radicand bits in, one root bit out
// depends on rpa_pkg
module rpa_sqrt_cell import rpa_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  input  sqrt_t data_i,
  output logic  valid_o,
  output sqrt_t data_o
);

  logic  valid_q;
  sqrt_t data_q, data_d;
  logic [35:0] rem_w, trial_w;

  always_comb begin
    rem_w = {data_i.rem, data_i.n[63:62]};
    trial_w = {2'b00, data_i.root, 2'b01};
    data_d = data_i;
    data_d.n = {data_i.n[61:0], 2'b00};
    if (rem_w >= trial_w) begin
      data_d.rem = 34'(rem_w - trial_w);
      data_d.root = {data_i.root[30:0], 1'b1};
    end else begin
      data_d.rem = rem_w[33:0];
      data_d.root = {data_i.root[30:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o = data_q;

endmodule

### rtl/rpa_div_cell.sv
// one quotient bit of the three axis divisions by the common root
// depends on rpa_pkg
module rpa_div_cell import rpa_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  input  divs_t data_i,
  output logic  valid_o,
  output divs_t data_o
);

  logic  valid_q;
  divs_t data_q, data_d;
  logic [32:0] t_w [3];

  always_comb begin
    data_d = data_i;
    for (int j = 0; j < 3; j++) begin
      t_w[j] = {data_i.rem[j], data_i.dbits[j][30]};
      data_d.dbits[j] = {data_i.dbits[j][29:0], 1'b0};
      if (t_w[j] >= {1'b0, data_i.r}) begin
        data_d.rem[j] = 32'(t_w[j] - {1'b0, data_i.r});
        data_d.quo[j] = {data_i.quo[j][29:0], 1'b1};
      end else begin
        data_d.rem[j] = t_w[j][31:0];
        data_d.quo[j] = {data_i.quo[j][29:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o = data_q;

endmodule

### rtl/rpa_cordic_cell.sv
// one rotation-mode cordic micro-rotation, step number given by idx_i
// depends on rpa_pkg (arctangent table)
module rpa_cordic_cell import rpa_pkg::*; (
  input  logic       clk_i,
  input  logic [4:0] idx_i,
  input  cordic_t    data_i,
  output cordic_t    data_o
);

  cordic_t data_q, data_d;
  logic signed [32:0] xs_w, ys_w, at_w;

  always_comb begin
    xs_w = data_i.x >>> idx_i;
    ys_w = data_i.y >>> idx_i;
    at_w = $signed({1'b0, ATAN_TURNS[idx_i]});
    data_d = data_i;
    if (!data_i.z[32]) begin
      data_d.x = data_i.x - ys_w;
      data_d.y = data_i.y + xs_w;
      data_d.z = data_i.z - at_w;
    end else begin
      data_d.x = data_i.x + ys_w;
      data_d.y = data_i.y - xs_w;
      data_d.z = data_i.z + at_w;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

### rtl/rpa_rodrigues.sv
// eight-stage back end: unit axis, rodrigues sum, saturation and zero-axis bypass
// depends on rpa_pkg
module rpa_rodrigues import rpa_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  divs_t            data_i,
  input  trig_t            trig_i,
  output logic             valid_o,
  output logic [2:0][31:0] out_o,
  output logic             zero_o,
  output logic             sat_o
);

  logic [BACK_REGS-1:0] valid_q;

  // stage 1
  logic signed [31:0] k1_q [3], k1_d [3];
  logic signed [32:0] d1_q [3], d1_d [3];
  logic signed [31:0] piv1_q [3], p1_q [3];
  logic               zero1_q;
  trig_t              trig1_q;
  // stage 2
  logic signed [31:0] k2_q [3];
  logic signed [32:0] d2_q [3];
  logic signed [34:0] kd2_q [3], kd2_d [3];
  logic signed [64:0] pr2_q [6], pr2_d [6];
  logic signed [64:0] prod2_w [3];
  logic signed [31:0] piv2_q [3], p2_q [3];
  logic               zero2_q;
  trig_t              trig2_q;
  // stage 3
  logic signed [31:0] k3_q [3];
  logic signed [32:0] d3_q [3];
  logic signed [34:0] kd3_q, kd3_d;
  logic signed [35:0] cr3_q [3], cr3_d [3];
  logic signed [64:0] dif3_w [3];
  logic signed [31:0] piv3_q [3], p3_q [3];
  logic               zero3_q;
  trig_t              trig3_q;
  // stage 4
  logic signed [32:0] d4_q [3];
  logic signed [35:0] par4_q [3], par4_d [3], crs4_q [3], crs4_d [3];
  logic signed [66:0] pp4_w [3];
  logic signed [67:0] cs4_w [3];
  logic signed [31:0] piv4_q [3], p4_q [3], cos4_q;
  logic               zero4_q;
  // stage 5
  logic signed [36:0] perp5_q [3], perp5_d [3];
  logic signed [35:0] par5_q [3], crs5_q [3];
  logic signed [31:0] piv5_q [3], p5_q [3], cos5_q;
  logic               zero5_q;
  // stage 6
  logic signed [37:0] pc6_q [3], pc6_d [3];
  logic signed [68:0] pcp6_w [3];
  logic signed [35:0] par6_q [3], crs6_q [3];
  logic signed [31:0] piv6_q [3], p6_q [3];
  logic               zero6_q;
  // stage 7
  logic signed [39:0] v7_q [3], v7_d [3];
  logic signed [31:0] p7_q [3];
  logic               zero7_q;
  // stage 8
  logic [2:0][31:0] out8_q, out8_d;
  logic             zero8_q, sat8_q, sat8_d;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      k1_d[j] = data_i.side.neg[j] ? -$signed({1'b0, data_i.quo[j]})
                                   : $signed({1'b0, data_i.quo[j]});
      d1_d[j] = 33'($signed(data_i.side.p[j])) - 33'($signed(data_i.side.piv[j]));
      prod2_w[j] = k1_q[j] * d1_q[j];
      kd2_d[j] = 35'(prod2_w[j] >>> 30);
    end
    pr2_d[0] = k1_q[1] * d1_q[2];
    pr2_d[1] = k1_q[2] * d1_q[1];
    pr2_d[2] = k1_q[2] * d1_q[0];
    pr2_d[3] = k1_q[0] * d1_q[2];
    pr2_d[4] = k1_q[0] * d1_q[1];
    pr2_d[5] = k1_q[1] * d1_q[0];
    kd3_d = kd2_q[0] + kd2_q[1] + kd2_q[2];
    for (int j = 0; j < 3; j++) begin
      dif3_w[j] = pr2_q[2*j] - pr2_q[2*j+1];
      cr3_d[j] = 36'(dif3_w[j] >>> 30);
      pp4_w[j] = k3_q[j] * kd3_q;
      par4_d[j] = 36'(pp4_w[j] >>> 30);
      cs4_w[j] = cr3_q[j] * trig3_q.sinv;
      crs4_d[j] = 36'(cs4_w[j] >>> 30);
      perp5_d[j] = 37'(d4_q[j]) - 37'(par4_q[j]);
      pcp6_w[j] = perp5_q[j] * cos5_q;
      pc6_d[j] = 38'(pcp6_w[j] >>> 30);
      v7_d[j] = 40'(piv6_q[j]) + 40'(par6_q[j]) + 40'(pc6_q[j]) + 40'(crs6_q[j]);
    end
  end

  always_comb begin
    sat8_d = 1'b0;
    for (int j = 0; j < 3; j++) begin
      if (zero7_q) begin
        out8_d[j] = p7_q[j];
      end else if (v7_q[j] > COORD_MAX) begin
        out8_d[j] = 32'(COORD_MAX);
        sat8_d = 1'b1;
      end else if (v7_q[j] < COORD_MIN) begin
        out8_d[j] = 32'(COORD_MIN);
        sat8_d = 1'b1;
      end else begin
        out8_d[j] = v7_q[j][31:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[BACK_REGS-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < 3; j++) begin
      k1_q[j] <= k1_d[j];
      d1_q[j] <= d1_d[j];
      piv1_q[j] <= $signed(data_i.side.piv[j]);
      p1_q[j] <= $signed(data_i.side.p[j]);
      k2_q[j] <= k1_q[j];
      d2_q[j] <= d1_q[j];
      kd2_q[j] <= kd2_d[j];
      piv2_q[j] <= piv1_q[j];
      p2_q[j] <= p1_q[j];
      k3_q[j] <= k2_q[j];
      d3_q[j] <= d2_q[j];
      cr3_q[j] <= cr3_d[j];
      piv3_q[j] <= piv2_q[j];
      p3_q[j] <= p2_q[j];
      d4_q[j] <= d3_q[j];
      par4_q[j] <= par4_d[j];
      crs4_q[j] <= crs4_d[j];
      piv4_q[j] <= piv3_q[j];
      p4_q[j] <= p3_q[j];
      perp5_q[j] <= perp5_d[j];
      par5_q[j] <= par4_q[j];
      crs5_q[j] <= crs4_q[j];
      piv5_q[j] <= piv4_q[j];
      p5_q[j] <= p4_q[j];
      pc6_q[j] <= pc6_d[j];
      par6_q[j] <= par5_q[j];
      crs6_q[j] <= crs5_q[j];
      piv6_q[j] <= piv5_q[j];
      p6_q[j] <= p5_q[j];
      v7_q[j] <= v7_d[j];
      p7_q[j] <= p6_q[j];
    end
    for (int j = 0; j < 6; j++) begin
      pr2_q[j] <= pr2_d[j];
    end
    zero1_q <= data_i.side.zero;
    trig1_q <= trig_i;
    zero2_q <= zero1_q;
    trig2_q <= trig1_q;
    kd3_q <= kd3_d;
    zero3_q <= zero2_q;
    trig3_q <= trig2_q;
    cos4_q <= trig3_q.cosv;
    zero4_q <= zero3_q;
    cos5_q <= cos4_q;
    zero5_q <= zero4_q;
    zero6_q <= zero5_q;
    zero7_q <= zero6_q;
    out8_q <= out8_d;
    zero8_q <= zero7_q;
    sat8_q <= sat8_d;
  end

  assign valid_o = valid_q[BACK_REGS-1];
  assign out_o = out8_q;
  assign zero_o = zero8_q;
  assign sat_o = sat8_q;

endmodule

### rtl/rotate_point_about_axis_3d_unit.sv
// top level: rotation of a point about an arbitrary axis, fully pipelined
// depends on rpa_pkg, rpa_sqrt_cell, rpa_div_cell, rpa_cordic_cell, rpa_rodrigues
//
// One item is taken on every cycle that start is high; busy stays low, since the
// pipeline never stalls. Each result appears on done_o for exactly one cycle,
// LATENCY (76) cycles after its transfer, and must be taken then. The latency is
// set by the chain of 32 square-root cells and 31 divider cells that normalize
// the axis; the sine/cosine cells run alongside and are delayed to match.
module rotate_point_about_axis_3d_unit import rpa_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] point_x_i,
  input  logic [31:0] point_y_i,
  input  logic [31:0] point_z_i,
  input  logic [31:0] pivot_x_i,
  input  logic [31:0] pivot_y_i,
  input  logic [31:0] pivot_z_i,
  input  logic [31:0] dir_x_i,
  input  logic [31:0] dir_y_i,
  input  logic [31:0] dir_z_i,
  input  logic [31:0] turn_angle_i,
  output logic        done_o,
  output logic [31:0] out_x_o,
  output logic [31:0] out_y_o,
  output logic [31:0] out_z_o,
  output logic        axis_was_zero_o,
  output logic        saturated_o
);

  // input register
  logic             v0_q;
  logic [2:0][31:0] p0_q, piv0_q, dir0_q;
  logic [31:0]      ang0_q;
  // normalize stages
  logic             v1_q, v2_q, v3_q, v4_q;
  side_t            side1_q, side1_d, side2_q, side3_q, side4_q;
  logic [2:0][31:0] mag1_q, mag1_d, mag2_q, mag3_q, mag3_d;
  logic [31:0]      or1_q;
  logic [4:0]       sh2_q, sh2_d;
  logic [2:0][63:0] sq4_q, sq4_d;
  logic [2:0][31:0] mag4_q;
  // chains
  logic    sq_v [SQRT_CELLS+1];
  sqrt_t   sq_data [SQRT_CELLS+1];
  logic    dv_v [DIV_CELLS+1];
  divs_t   dv_data [DIV_CELLS+1];
  cordic_t cd_data [TRIG_CELLS+1];
  trig_t   tdl_q [TRIG_DELAY];
  trig_t   trig_d;
  logic signed [32:0] xr_w, yr_w;
  logic [2:0][31:0] res_w;

  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v0_q <= start && !busy;
      v1_q <= v0_q;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p0_q <= {point_z_i, point_y_i, point_x_i};
    piv0_q <= {pivot_z_i, pivot_y_i, pivot_x_i};
    dir0_q <= {dir_z_i, dir_y_i, dir_x_i};
    ang0_q <= turn_angle_i;
  end

  // magnitudes
  always_comb begin
    side1_d.p = p0_q;
    side1_d.piv = piv0_q;
    for (int j = 0; j < 3; j++) begin
      side1_d.neg[j] = dir0_q[j][31];
      mag1_d[j] = dir0_q[j][31] ? 32'(-dir0_q[j]) : dir0_q[j];
    end
    side1_d.zero = (dir0_q == '0);
  end

  // left shift that brings the largest magnitude to bit 30 or 31
  always_comb begin
    sh2_d = '0;
    for (int i = 0; i < 30; i++) begin
      if (or1_q[i]) begin
        sh2_d = 5'(30 - i);
      end
    end
    if (or1_q[31] || or1_q[30]) begin
      sh2_d = '0;
    end
  end

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      mag3_d[j] = mag2_q[j] << sh2_q;
      sq4_d[j] = 64'(mag3_q[j]) * 64'(mag3_q[j]);
    end
  end

  always_ff @(posedge clk_i) begin
    side1_q <= side1_d;
    mag1_q <= mag1_d;
    or1_q <= mag1_d[0] | mag1_d[1] | mag1_d[2];
    side2_q <= side1_q;
    mag2_q <= mag1_q;
    sh2_q <= sh2_d;
    side3_q <= side2_q;
    mag3_q <= mag3_d;
    side4_q <= side3_q;
    mag4_q <= mag3_q;
    sq4_q <= sq4_d;
  end

  // square root chain
  always_comb begin
    sq_v[0] = v4_q;
    sq_data[0].side = side4_q;
    sq_data[0].mag = mag4_q;
    sq_data[0].n = sq4_q[0] + sq4_q[1] + sq4_q[2];
    sq_data[0].rem = '0;
    sq_data[0].root = '0;
  end

  for (genvar i = 0; i < SQRT_CELLS; i++) begin : g_sqrt
    rpa_sqrt_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(sq_v[i]),
      .data_i (sq_data[i]),
      .valid_o(sq_v[i+1]),
      .data_o (sq_data[i+1])
    );
  end

  // division chain
  always_comb begin
    dv_v[0] = sq_v[SQRT_CELLS];
    dv_data[0].side = sq_data[SQRT_CELLS].side;
    dv_data[0].r = sq_data[SQRT_CELLS].root;
    for (int j = 0; j < 3; j++) begin
      dv_data[0].rem[j] = {1'b0, sq_data[SQRT_CELLS].mag[j][31:1]};
      dv_data[0].dbits[j] = {sq_data[SQRT_CELLS].mag[j][0], 30'd0};
      dv_data[0].quo[j] = '0;
    end
  end

  for (genvar i = 0; i < DIV_CELLS; i++) begin : g_div
    rpa_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(dv_v[i]),
      .data_i (dv_data[i]),
      .valid_o(dv_v[i+1]),
      .data_o (dv_data[i+1])
    );
  end

  // sine and cosine chain
  always_comb begin
    cd_data[0].x = CORDIC_GAIN;
    cd_data[0].y = '0;
    cd_data[0].z = $signed({{3{ang0_q[29]}}, ang0_q[29:0]});
    cd_data[0].quad = quad_e'(2'(ang0_q[31:30] + {1'b0, ang0_q[29]}));
  end

  for (genvar i = 0; i < TRIG_CELLS; i++) begin : g_cordic
    rpa_cordic_cell u_cell (
      .clk_i (clk_i),
      .idx_i (5'(i)),
      .data_i(cd_data[i]),
      .data_o(cd_data[i+1])
    );
  end

  // quadrant fold and clamp to one
  always_comb begin
    unique case (cd_data[TRIG_CELLS].quad)
      QUAD_0: begin
        xr_w = cd_data[TRIG_CELLS].x;
        yr_w = cd_data[TRIG_CELLS].y;
      end
      QUAD_90: begin
        xr_w = -cd_data[TRIG_CELLS].y;
        yr_w = cd_data[TRIG_CELLS].x;
      end
      QUAD_180: begin
        xr_w = -cd_data[TRIG_CELLS].x;
        yr_w = -cd_data[TRIG_CELLS].y;
      end
      default: begin
        xr_w = cd_data[TRIG_CELLS].y;
        yr_w = -cd_data[TRIG_CELLS].x;
      end
    endcase
    if (xr_w > ONE_Q30) begin
      trig_d.cosv = 32'(ONE_Q30);
    end else if (xr_w < -ONE_Q30) begin
      trig_d.cosv = 32'(-ONE_Q30);
    end else begin
      trig_d.cosv = xr_w[31:0];
    end
    if (yr_w > ONE_Q30) begin
      trig_d.sinv = 32'(ONE_Q30);
    end else if (yr_w < -ONE_Q30) begin
      trig_d.sinv = 32'(-ONE_Q30);
    end else begin
      trig_d.sinv = yr_w[31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    tdl_q[0] <= trig_d;
    for (int i = 1; i < TRIG_DELAY; i++) begin
      tdl_q[i] <= tdl_q[i-1];
    end
  end

  rpa_rodrigues u_rodrigues (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(dv_v[DIV_CELLS]),
    .data_i (dv_data[DIV_CELLS]),
    .trig_i (tdl_q[TRIG_DELAY-1]),
    .valid_o(done_o),
    .out_o  (res_w),
    .zero_o (axis_was_zero_o),
    .sat_o  (saturated_o)
  );

  assign out_x_o = res_w[0];
  assign out_y_o = res_w[1];
  assign out_z_o = res_w[2];

  // assertions
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |-> ##LATENCY done_o)
    else $error("transfer without result");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start, LATENCY))
    else $error("result without transfer");

  a_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(axis_was_zero_o && saturated_o))
    else $error("zero axis with saturation");

  a_zero_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && axis_was_zero_o) |-> (out_x_o == $past(point_x_i, LATENCY)))
    else $error("zero axis point altered");

endmodule
